@@ rtl/core/dcmf_pkg.sv @@
// ---------------------------------------------------------------------------
// dcmf_pkg : shared constants and helpers for the dark channel min filter
// Geometry limits, register codes and the edge mirroring function.
// ---------------------------------------------------------------------------
package dcmf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int POS_BITS    = 11;              // row / column positions
   localparam int DIM_BITS    = 12;              // width / height registers
   localparam int PATCH_BITS  = 4;
   localparam int RAD_BITS    = 3;
   localparam int MAX_DIM     = 2048;
   localparam int MAX_RADIUS  = 7;
   localparam int LINE_ROWS   = 16;              // rows held, power of two
   localparam int ROW_SEL_BITS = $clog2(LINE_ROWS);
   localparam int ADDR_BITS   = ROW_SEL_BITS + POS_BITS;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATCH_SIZE   = 2'd2;

   localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RST  = 12'd640;
   localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RST = 12'd480;
   localparam logic [PATCH_BITS-1:0] PATCH_SIZE_RST   = 4'd15;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Mirror a window position into 0..n-1, edge pixel repeated
   function automatic logic [POS_BITS-1:0] mirror(input logic signed [DIM_BITS:0] o,
                                                   input logic [DIM_BITS-1:0] n);
      logic signed [DIM_BITS+1:0] ox;
      logic signed [DIM_BITS+1:0] nx;
      logic signed [DIM_BITS+1:0] res;
      ox = {o[DIM_BITS], o};
      nx = $signed({2'b00, n});
      if (ox < 0) begin
         res = -ox - 14'sd1;
      end else if (ox > nx - 14'sd1) begin
         res = (nx <<< 1) - 14'sd1 - ox;
      end else begin
         res = ox;
      end
      return res[POS_BITS-1:0];
   endfunction

endpackage

@@ rtl/core/dcmf_req_if.sv @@
// ---------------------------------------------------------------------------
// dcmf_req_if : pixel / command channel
// Valid-ready channel carrying one command word with its RGB sample.
// ---------------------------------------------------------------------------
interface dcmf_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [dcmf_pkg::SAMPLE_BITS-1:0] red;
   logic [dcmf_pkg::SAMPLE_BITS-1:0] green;
   logic [dcmf_pkg::SAMPLE_BITS-1:0] blue;

   modport source (output valid, cmd, red, green, blue, input ready);
   modport sink   (input valid, cmd, red, green, blue, output ready);
endinterface

@@ rtl/core/dcmf_rsp_if.sv @@
// ---------------------------------------------------------------------------
// dcmf_rsp_if : dark channel result channel
// Valid-ready channel carrying one filtered pixel word with its position.
// ---------------------------------------------------------------------------
interface dcmf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dcmf_pkg::SAMPLE_BITS-1:0] dark_value;
   logic [dcmf_pkg::POS_BITS-1:0]    out_row;
   logic [dcmf_pkg::POS_BITS-1:0]    out_col;
   logic                             frame_last;

   modport source (output valid, dark_value, out_row, out_col, frame_last, input ready);
   modport sink   (input valid, dark_value, out_row, out_col, frame_last, output ready);
endinterface

@@ rtl/core/dark_channel_min_filter_core.sv @@
// A word that yields a result starts a scan of its (2R+1) x (2R+1) window, one line
//   store read per window pixel (R = effective radius, up to 7), then the result is registered.
// Throughput: one word per cycle when no result is due; no word is taken while a scan runs
//   or a result waits for the receiver. The line store has a single read port.
// Reset: synchronous; counters clear, registers take 640 x 480, patch 15.
//   The line store is not cleared; entries are always written before they are read.
// ---------------------------------------------------------------------------
// dark_channel_min_filter_core : streaming dark channel minimum filter
// Keeps per-pixel RGB minima in a 16-row line store and scans the mirrored
// window of each output pixel through the store's read port.
// ---------------------------------------------------------------------------
module dark_channel_min_filter_core (
   input  logic                                   clock,
   input  logic                                   reset,
   dcmf_req_if.sink                               req_bus,
   dcmf_rsp_if.source                             rsp_bus,
   input  logic                                   csr_we,
   input  logic [dcmf_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [dcmf_pkg::DIM_BITS-1:0]          csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_DONE} state_type;

   localparam int SB = dcmf_pkg::SAMPLE_BITS;
   localparam int PB = dcmf_pkg::POS_BITS;
   localparam int DB = dcmf_pkg::DIM_BITS;
   localparam int RB = dcmf_pkg::RAD_BITS;

   state_type state_ff;

   logic [DB-1:0] frame_width_ff, frame_height_ff;
   logic [dcmf_pkg::PATCH_BITS-1:0] patch_size_ff;
   logic [PB-1:0] in_row_ff, in_col_ff, out_row_ff, out_col_ff;
   logic          in_done_ff;
   logic signed [RB+1:0] dr_ff, dc_ff;
   logic [SB-1:0] best_ff;
   logic          rd_valid_ff;
   logic [SB-1:0] rd_data_ff;

   logic          rsp_valid_ff;
   logic [SB-1:0] rsp_dark_ff;
   logic [PB-1:0] rsp_row_ff, rsp_col_ff;
   logic          rsp_last_ff;

   // line store
   logic [SB-1:0] line_mem [dcmf_pkg::LINE_ROWS * dcmf_pkg::MAX_DIM];

   // effective geometry
   logic [DB-1:0] eff_w, eff_h;
   logic [RB-1:0] eff_r;
   always_comb begin
      eff_w = frame_width_ff;
      if (eff_w == '0) eff_w = DB'(1);
      if (eff_w > DB'(dcmf_pkg::MAX_DIM)) eff_w = DB'(dcmf_pkg::MAX_DIM);
      eff_h = frame_height_ff;
      if (eff_h == '0) eff_h = DB'(1);
      if (eff_h > DB'(dcmf_pkg::MAX_DIM)) eff_h = DB'(dcmf_pkg::MAX_DIM);
      eff_r = patch_size_ff[dcmf_pkg::PATCH_BITS-1:1];
      if ({{(DB-RB){1'b0}}, eff_r} > eff_w - DB'(1)) eff_r = RB'(eff_w - DB'(1));
      if ({{(DB-RB){1'b0}}, eff_r} > eff_h - DB'(1)) eff_r = RB'(eff_h - DB'(1));
   end

   logic signed [RB+1:0] r_s;
   assign r_s = $signed({2'b00, eff_r});

   // bottom-right corner of the next output's window
   logic [DB-1:0] nr, nc;
   always_comb begin
      nr = {1'b0, out_row_ff} + DB'(eff_r);
      if (nr > eff_h - DB'(1)) nr = eff_h - DB'(1);
      nc = {1'b0, out_col_ff} + DB'(eff_r);
      if (nc > eff_w - DB'(1)) nc = eff_w - DB'(1);
   end

   // acceptance decode
   logic          accept, push_ok, emit_ok;
   logic [SB-1:0] pix_min;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept  = req_bus.valid && req_bus.ready;
   assign push_ok = (req_bus.cmd == dcmf_pkg::CMD_PUSH) && !in_done_ff;

   always_comb begin
      pix_min = (req_bus.red < req_bus.green) ? req_bus.red : req_bus.green;
      if (req_bus.blue < pix_min) pix_min = req_bus.blue;
      if (push_ok) begin
         emit_ok = (nr < {1'b0, in_row_ff}) ||
                   ((nr == {1'b0, in_row_ff}) && (nc <= {1'b0, in_col_ff}));
      end else if (in_done_ff) begin
         emit_ok = 1'b1;
      end else begin
         emit_ok = (nr < {1'b0, in_row_ff}) ||
                   ((nr == {1'b0, in_row_ff}) && (nc < {1'b0, in_col_ff}));
      end
   end

   // window read address
   logic [PB-1:0] mr, mc;
   logic [dcmf_pkg::ADDR_BITS-1:0] rd_addr, wr_addr;
   logic rd_issue, scan_end;
   always_comb begin
      mr = dcmf_pkg::mirror($signed({2'b00, out_row_ff}) + (DB+1)'(dr_ff), eff_h);
      mc = dcmf_pkg::mirror($signed({2'b00, out_col_ff}) + (DB+1)'(dc_ff), eff_w);
   end
   assign rd_addr  = {mr[dcmf_pkg::ROW_SEL_BITS-1:0], mc};
   assign wr_addr  = {in_row_ff[dcmf_pkg::ROW_SEL_BITS-1:0], in_col_ff};
   assign rd_issue = (state_ff == ST_SCAN);
   assign scan_end = (dr_ff == r_s) && (dc_ff == r_s);

   // store access: write on push, one read per scan cycle
   always_ff @(posedge clock) begin
      if (accept && push_ok) begin
         line_mem[wr_addr] <= pix_min;
      end
      if (rd_issue) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // running minimum, preset when a scan starts
   logic          scan_start;
   logic [SB-1:0] best_in;
   assign scan_start = accept && emit_ok;
   assign best_in = scan_start ? '1 :
                    (rd_valid_ff && (rd_data_ff < best_ff)) ? rd_data_ff : best_ff;

   logic out_free, frame_end;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign frame_end = ({1'b0, out_row_ff} == eff_h - DB'(1)) &&
                      ({1'b0, out_col_ff} == eff_w - DB'(1));

   // sequencer, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= dcmf_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= dcmf_pkg::FRAME_HEIGHT_RST;
         patch_size_ff   <= dcmf_pkg::PATCH_SIZE_RST;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         in_done_ff      <= 1'b0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= rd_issue;
         best_ff     <= best_in;
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_bus.ready) rsp_valid_ff <= 1'b0;

         // register writes restart the frame
         if (csr_we) begin
            case (csr_index)
               dcmf_pkg::CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_wdata;
               end
               dcmf_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata;
               end
               dcmf_pkg::CSR_PATCH_SIZE: begin
                  patch_size_ff <= csr_wdata[dcmf_pkg::PATCH_BITS-1:0];
               end
               default: begin
               end
            endcase
            if (csr_index == dcmf_pkg::CSR_FRAME_WIDTH ||
                csr_index == dcmf_pkg::CSR_FRAME_HEIGHT ||
                csr_index == dcmf_pkg::CSR_PATCH_SIZE) begin
               in_row_ff  <= '0;
               in_col_ff  <= '0;
               out_row_ff <= '0;
               out_col_ff <= '0;
               in_done_ff <= 1'b0;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (push_ok) begin
                     if ({1'b0, in_col_ff} + DB'(1) >= eff_w) begin
                        in_col_ff <= '0;
                        if ({1'b0, in_row_ff} + DB'(1) >= eff_h) in_done_ff <= 1'b1;
                        else in_row_ff <= in_row_ff + PB'(1);
                     end else begin
                        in_col_ff <= in_col_ff + PB'(1);
                     end
                  end
                  if (emit_ok) begin
                     dr_ff    <= -r_s;
                     dc_ff    <= -r_s;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (scan_end) begin
                  state_ff <= ST_LAST;
               end else if (dc_ff == r_s) begin
                  dc_ff <= -r_s;
                  dr_ff <= dr_ff + (RB+2)'(1);
               end else begin
                  dc_ff <= dc_ff + (RB+2)'(1);
               end
            end
            ST_LAST: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_dark_ff  <= best_ff;
                  rsp_row_ff   <= out_row_ff;
                  rsp_col_ff   <= out_col_ff;
                  rsp_last_ff  <= frame_end;
                  state_ff     <= ST_IDLE;
                  if (frame_end) begin
                     in_row_ff  <= '0;
                     in_col_ff  <= '0;
                     out_row_ff <= '0;
                     out_col_ff <= '0;
                     in_done_ff <= 1'b0;
                  end else if ({1'b0, out_col_ff} + DB'(1) >= eff_w) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_ff + PB'(1);
                  end else begin
                     out_col_ff <= out_col_ff + PB'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.dark_value = rsp_dark_ff;
   assign rsp_bus.out_row    = rsp_row_ff;
   assign rsp_bus.out_col    = rsp_col_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

   // checks
   a_done_col_zero: assert property (@(posedge clock) disable iff (reset)
      in_done_ff |-> (in_col_ff == '0))
      else $error("input column not wrapped after last pixel");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (dc_ff <= r_s && dc_ff >= -r_s && dr_ff <= r_s && dr_ff >= -r_s))
      else $error("window offset outside radius");

   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      !in_done_ff |-> ((out_row_ff < in_row_ff) ||
                       (out_row_ff == in_row_ff && out_col_ff <= in_col_ff)))
      else $error("output position ahead of input");

endmodule

@@ tb/dark_channel_min_filter_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dark_channel_min_filter_core_test : self-checking bench for the dark channel core
// Streams frames of RGB words, some cut short, under a range of geometries and patch sizes.
// A behavioural filter in the bench predicts every result word. Both ends of the
// valid-ready channels idle at random, and one long receiver hold fills the core.
// ---------------------------------------------------------------------------
module dark_channel_min_filter_core_test;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 300;        // covers a full window scan at the largest radius
   localparam int BIG_FRAME   = 200;        // larger frames are cut short
   localparam int BIG_CUT     = 60;

   typedef struct packed {
      logic [dcmf_pkg::SAMPLE_BITS-1:0] dark_value;
      logic [dcmf_pkg::POS_BITS-1:0]    out_row;
      logic [dcmf_pkg::POS_BITS-1:0]    out_col;
      logic                             frame_last;
   } dark_word_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic          cmd;
      logic [15:0]   red, green, blue;   // ROW_CSR: red = index, green = data
      bit            typed;              // expected result written out below
      bit            has_res;
      dark_word_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_we    = 1'b0;
   logic [dcmf_pkg::CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [dcmf_pkg::DIM_BITS-1:0]       csr_wdata = '0;

   dcmf_req_if req_if ();
   dcmf_rsp_if rsp_if ();

   dark_channel_min_filter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the filter state
   int unsigned cfg_width, cfg_height, cfg_patch;
   int unsigned pos_in_row, pos_in_col, pos_out_row, pos_out_col;
   bit          frame_in_done;
   bit          frame_closed;               // set when frame_last word is predicted
   bit [15:0]   pixel_min_store [int];

   dark_word_type dark_expected_q [$];
   int          fail_count   = 0;
   int          cycle_count  = 0;
   int          sent_words   = 0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   int          long_hold_req  = 0;

   // clock and timeout
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[dark_channel_min_filter_core] ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold on request
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req != 0) begin
            hold = long_hold_req;
            long_hold_req = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      dark_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (dark_expected_q.size() == 0) begin
            $error("unexpected result word row %0d col %0d", rsp_if.out_row, rsp_if.out_col);
            fail_count++;
         end else begin
            want = dark_expected_q.pop_front();
            if (rsp_if.dark_value !== want.dark_value) begin
               $error("dark_value exp %0d got %0d", want.dark_value, rsp_if.dark_value);
               fail_count++;
            end
            if (rsp_if.out_row !== want.out_row) begin
               $error("out_row exp %0d got %0d", want.out_row, rsp_if.out_row);
               fail_count++;
            end
            if (rsp_if.out_col !== want.out_col) begin
               $error("out_col exp %0d got %0d", want.out_col, rsp_if.out_col);
               fail_count++;
            end
            if (rsp_if.frame_last !== want.frame_last) begin
               $error("frame_last exp %0d got %0d", want.frame_last, rsp_if.frame_last);
               fail_count++;
            end
         end
      end
   end

   // geometry after clamping
   function automatic int unsigned geo_width();
      return (cfg_width < 1) ? 1 :
             (cfg_width > dcmf_pkg::MAX_DIM) ? dcmf_pkg::MAX_DIM : cfg_width;
   endfunction

   function automatic int unsigned geo_height();
      return (cfg_height < 1) ? 1 :
             (cfg_height > dcmf_pkg::MAX_DIM) ? dcmf_pkg::MAX_DIM : cfg_height;
   endfunction

   function automatic int reflect(int o, int n);
      if (o < 0) return -o - 1;
      if (o > n - 1) return 2 * n - 1 - o;
      return o;
   endfunction

   function automatic void restart_frame();
      pos_in_row = 0; pos_in_col = 0; pos_out_row = 0; pos_out_col = 0;
      frame_in_done = 0;
   endfunction

   // next output pixel, if its window has fully arrived
   function automatic bit window_min(int unsigned avail, bit fwd, int unsigned fwd_idx,
                                     bit [15:0] fwd_val, output dark_word_type res);
      int unsigned w, h, nr, nc, idx;
      int r;
      bit [15:0] best, v;
      w = geo_width();
      h = geo_height();
      r = cfg_patch / 2;
      if (r > dcmf_pkg::MAX_RADIUS) r = dcmf_pkg::MAX_RADIUS;
      if (r > w - 1) r = w - 1;
      if (r > h - 1) r = h - 1;
      nr = pos_out_row + r;
      nc = pos_out_col + r;
      if (nr > h - 1) nr = h - 1;
      if (nc > w - 1) nc = w - 1;
      res = '0;
      if (nr * w + nc >= avail) return 0;
      best = 16'hFFFF;
      for (int dr = -r; dr <= r; dr++) begin
         for (int dc = -r; dc <= r; dc++) begin
            idx = reflect(pos_out_row + dr, h) * w + reflect(pos_out_col + dc, w);
            v = (fwd && idx == fwd_idx) ? fwd_val : pixel_min_store[idx];
            if (v < best) best = v;
         end
      end
      res.dark_value = best;
      res.out_row    = pos_out_row[dcmf_pkg::POS_BITS-1:0];
      res.out_col    = pos_out_col[dcmf_pkg::POS_BITS-1:0];
      res.frame_last = (pos_out_row == h - 1 && pos_out_col == w - 1);
      if (pos_out_col + 1 >= w) begin
         pos_out_col = 0;
         pos_out_row++;
      end else begin
         pos_out_col++;
      end
      return 1;
   endfunction

   // one accepted word through the bench filter
   function automatic bit predict_dark(logic cmd, bit [15:0] r, bit [15:0] g, bit [15:0] b,
                                       output dark_word_type res);
      int unsigned w, h, p;
      bit [15:0] v;
      bit got;
      w = geo_width();
      h = geo_height();
      if (cmd == dcmf_pkg::CMD_PUSH && !frame_in_done) begin
         v = (r < g) ? r : g;
         if (b < v) v = b;
         p = pos_in_row * w + pos_in_col;
         got = window_min(p + 1, 1, p, v, res);
         pixel_min_store[p] = v;
         if (pos_in_col + 1 >= w) begin
            pos_in_col = 0;
            if (pos_in_row + 1 >= h) frame_in_done = 1;
            else pos_in_row++;
         end else begin
            pos_in_col++;
         end
      end else begin
         got = window_min(frame_in_done ? w * h : pos_in_row * w + pos_in_col, 0, 0, 0, res);
      end
      if (got && res.frame_last) begin
         restart_frame();
         frame_closed = 1;
      end
      return got;
   endfunction

   // present one word, wait for acceptance, record what it should produce
   task automatic send_word(logic cmd, bit [15:0] r, bit [15:0] g, bit [15:0] b,
                            bit typed = 0, bit typed_has = 0, dark_word_type typed_res = '0);
      dark_word_type res;
      bit got;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= cmd;
      req_if.red   <= r;
      req_if.green <= g;
      req_if.blue  <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      got = predict_dark(cmd, r, g, b, res);
      if (typed) begin
         got = typed_has;
         res = typed_res;
      end
      if (got) dark_expected_q.push_back(res);
      sent_words++;
   endtask

   // wait for every result, then for any window scan still running
   task automatic wait_quiet();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (dark_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [dcmf_pkg::CSR_IDX_BITS-1:0] idx, int unsigned data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[dcmf_pkg::DIM_BITS-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == dcmf_pkg::CSR_FRAME_WIDTH) cfg_width = data[11:0];
      else if (idx == dcmf_pkg::CSR_FRAME_HEIGHT) cfg_height = data[11:0];
      else if (idx == dcmf_pkg::CSR_PATCH_SIZE) cfg_patch = data[3:0];
      restart_frame();
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned p);
      wait_quiet();
      csr_write(dcmf_pkg::CSR_FRAME_WIDTH, w);
      csr_write(dcmf_pkg::CSR_FRAME_HEIGHT, h);
      csr_write(dcmf_pkg::CSR_PATCH_SIZE, p);
   endtask

   function automatic bit [15:0] rand_sample();
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return $urandom_range(16'hFFFF);
      endcase
   endfunction

   // one frame: pixels with stray drains, then drains (and late pushes) to empty it;
   // now and then, and always for a big frame, cut short by a register write
   task automatic run_frame();
      int unsigned n;
      int unsigned cut_at;
      bit cut;
      n = geo_width() * geo_height();
      cut = ($urandom_range(9) == 0) || (n > BIG_FRAME);
      cut_at = (n > BIG_FRAME) ? BIG_CUT : n / 2;
      frame_closed = 0;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            send_word(dcmf_pkg::CMD_DRAIN, rand_sample(), rand_sample(), rand_sample());
         if (cut && i == cut_at) begin
            set_geometry(cfg_width, cfg_height, cfg_patch);
            return;
         end
         send_word(dcmf_pkg::CMD_PUSH, rand_sample(), rand_sample(), rand_sample());
      end
      while (!frame_closed)
         send_word(($urandom_range(4) == 0) ? dcmf_pkg::CMD_PUSH : dcmf_pkg::CMD_DRAIN,
                   rand_sample(), rand_sample(), rand_sample());
   endtask

   stim_row_type directed [$];

   function automatic stim_row_type csr_row(int unsigned idx, int unsigned data);
      stim_row_type s;
      s = '{ROW_CSR, 1'b0, idx[15:0], data[15:0], 16'h0, 0, 0, '0};
      return s;
   endfunction

   function automatic stim_row_type word_row(logic c, bit [15:0] r, bit [15:0] g,
                                             bit [15:0] b, bit typed = 0, bit has = 0,
                                             dark_word_type res = '0);
      stim_row_type s;
      s = '{ROW_WORD, c, r, g, b, typed, has, res};
      return s;
   endfunction

   initial begin
      int phase;
      int unsigned w, h, p;
      req_if.valid = 1'b0;
      req_if.cmd   = dcmf_pkg::CMD_PUSH;
      req_if.red   = '0;
      req_if.green = '0;
      req_if.blue  = '0;
      cfg_width  = dcmf_pkg::FRAME_WIDTH_RST;
      cfg_height = dcmf_pkg::FRAME_HEIGHT_RST;
      cfg_patch  = dcmf_pkg::PATCH_SIZE_RST;
      restart_frame();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 2 x 2 with no window, results readable by eye
      directed.push_back(csr_row(dcmf_pkg::CSR_FRAME_WIDTH, 2));
      directed.push_back(csr_row(dcmf_pkg::CSR_FRAME_HEIGHT, 2));
      directed.push_back(csr_row(dcmf_pkg::CSR_PATCH_SIZE, 1));
      directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'h0, 16'h0, 16'h0, 1, 1,
                                  '{16'h0, 0, 0, 0}));
      directed.push_back(word_row(dcmf_pkg::CMD_DRAIN, 16'h1234, 16'h0, 16'hFFFF, 1, 0));
      directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1,
                                  '{16'hFFFF, 0, 1, 0}));
      directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'd5, 16'd9, 16'd7, 1, 1,
                                  '{16'd5, 1, 0, 0}));
      directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'd9, 16'hFFFF, 16'd3, 1, 1,
                                  '{16'd3, 1, 1, 1}));
      // 3 x 3 with a 3 x 3 window: mirrored edges, late pushes act as drains
      directed.push_back(csr_row(dcmf_pkg::CSR_FRAME_WIDTH, 3));
      directed.push_back(csr_row(dcmf_pkg::CSR_FRAME_HEIGHT, 3));
      directed.push_back(csr_row(dcmf_pkg::CSR_PATCH_SIZE, 3));
      for (int i = 0; i < 9; i++)
         directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'(1000 * (9 - i)),
                                     16'(40000 + i), 16'(i * 7000 + 1)));
      directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'hFFFF, 16'h0, 16'h0));
      directed.push_back(word_row(dcmf_pkg::CMD_PUSH, 16'h0, 16'hFFFF, 16'h0));
      directed.push_back(word_row(dcmf_pkg::CMD_DRAIN, 16'h0, 16'h0, 16'h0));
      directed.push_back(word_row(dcmf_pkg::CMD_DRAIN, 16'h0, 16'h0, 16'h0));
      directed.push_back(word_row(dcmf_pkg::CMD_DRAIN, 16'h0, 16'h0, 16'h0));

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            if (directed[i].red == dcmf_pkg::CSR_FRAME_WIDTH) wait_quiet();
            csr_write(directed[i].red[dcmf_pkg::CSR_IDX_BITS-1:0], directed[i].green);
         end else begin
            send_word(directed[i].cmd, directed[i].red, directed[i].green, directed[i].blue,
                      directed[i].typed, directed[i].has_res, directed[i].res);
         end
      end

      // random phases, idling pattern rotating, extremes mixed in
      phase = 0;
      while (sent_words < 750) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         case (phase)
            1: begin w = 2048; h = 1;    p = 15; end
            3: begin w = 15;   h = 8;    p = 14; end
            5: begin w = 0;    h = 40;   p = 0;  end
            7: begin w = 1;    h = 4095; p = 5;  end
            9: begin w = 8;    h = 8;    p = 15; end
            default: begin
               w = $urandom_range(12, 1);
               h = $urandom_range(8, 1);
               p = $urandom_range(15);
            end
         endcase
         set_geometry(w, h, p);
         if (phase == 2) long_hold_req = 500;
         repeat ($urandom_range(3, 1)) run_frame();
         phase++;
      end

      wait_quiet();
      if (fail_count == 0 && dark_expected_q.size() == 0) begin
         $display("[dark_channel_min_filter_core] OK");
      end else begin
         $display("[dark_channel_min_filter_core] ERROR");
      end
      $finish;
   end

endmodule
